@@ design/ptst_pkg.sv @@
// ----------------------------------------------------------------------------
// ptst_pkg: shared types and constants for the periodic timer slot table
// Request and status codes, payload structs and the per-cell control groups.
// ----------------------------------------------------------------------------
package ptst_pkg;

  // Table size and reset values
  localparam int unsigned SLOTS_DEF    = 8;
  localparam logic [15:0] WRAP_RESET   = 16'd65000;
  localparam logic [15:0] PERIOD_RESET = 16'd100;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [0:0]  REG_COUNT_WRAP = 1'b0;

  // Request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_REGISTER = 2'd1;
  localparam logic [1:0] REQ_DELETE   = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_TAKEN = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] period;
    logic        has_handler;
    logic [2:0]  slot_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  assigned_slot;
    logic [7:0]  fired_mask;
    logic [15:0] system_ticks;
    logic [3:0]  active_slots;
  } out_item_t;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic        tick;
    logic        reg_go;
    logic        del_go;
    logic [15:0] period;
  } cell_cmd_t;

  // Status returned by one cell
  typedef struct packed {
    logic taken;
    logic fired;
    logic claimed;
  } cell_stat_t;

endpackage

@@ design/ptst_cell.sv @@
// ----------------------------------------------------------------------------
// ptst_cell: one timer slot
// Holds the taken flag, period and counter of one slot. A search token runs
// along the row so the lowest open slot claims a register request.
// ----------------------------------------------------------------------------
module ptst_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ptst_pkg::cell_cmd_t cmd,
  input  logic               del_hit,
  input  logic               search_in,
  output logic               search_out,
  output ptst_pkg::cell_stat_t stat
);
  import ptst_pkg::*;

  logic        taken_r, taken_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] count_inc;
  logic        fire;
  logic        claim;

  // Pass the search on only past a taken slot
  assign search_out = search_in & taken_r;
  assign claim      = cmd.reg_go & search_in & ~taken_r;

  assign count_inc = count_r + 16'd1;
  assign fire      = taken_r && (count_inc >= period_r);

  // Next slot state
  always_comb begin
    taken_nxt  = taken_r;
    period_nxt = period_r;
    count_nxt  = count_r;
    if (cmd.tick) begin
      count_nxt = fire ? 16'd0 : count_inc;
    end
    if (claim) begin
      taken_nxt  = 1'b1;
      period_nxt = cmd.period;
    end
    if (cmd.del_go && del_hit) begin
      taken_nxt  = 1'b0;
      period_nxt = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r  <= 1'b0;
      period_r <= PERIOD_RESET;
      count_r  <= 16'd0;
    end else begin
      taken_r  <= taken_nxt;
      period_r <= period_nxt;
      count_r  <= count_nxt;
    end
  end

  assign stat.taken   = taken_r;
  assign stat.fired   = cmd.tick & fire;
  assign stat.claimed = claim;

endmodule

@@ design/periodic_timer_slot_table.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_slot_table: row of periodic timer slots with a tick count
// Takes tick, register, delete and clear requests and reports one result
// per request. An APB-style port holds the tick count wrap limit.
// ----------------------------------------------------------------------------
// The result appears on out_* with out_strobe in the cycle after start.
// Throughput: one request per cycle; busy stays low. Every slot cell updates
// in the same cycle and the open-slot search ripples through the cell row.
// Reset (rst_n low, synchronous): all slots open with period 100, counters
// and tick count zero, wrap limit 65000, no result pending.
module periodic_timer_slot_table #(
  parameter int unsigned SLOTS = ptst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ptst_pkg::in_item_t            in_item,
  output logic                          out_strobe,
  output ptst_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptst_pkg::CFG_AW-1:0]   paddr,
  input  logic [ptst_pkg::CFG_DW-1:0]   pwdata,
  output logic [ptst_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import ptst_pkg::*;

  localparam int unsigned CW_RAW = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W  = (CW_RAW > 4) ? CW_RAW : 4;

  logic [15:0]      wrap_r;
  logic [15:0]      ticks_r, ticks_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             strobe_r;
  out_item_t        out_r, out_nxt;

  cell_cmd_t        cmd;
  logic [SLOTS:0]   search;
  logic [SLOTS-1:0] del_hit;
  cell_stat_t       stat [SLOTS];

  logic             is_tick, is_reg, is_del, is_clr;
  logic             full, sel_taken, del_ok;
  logic [15:0]      tick_inc;
  logic [2:0]       assigned;
  logic [7:0]       fired;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_COUNT_WRAP) ? {16'd0, wrap_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= WRAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_AW-1] == REG_COUNT_WRAP) begin
      wrap_r <= pwdata[15:0];
    end
  end

  assign busy = 1'b0;

  // Decode the request
  assign is_tick = start && in_item.req_type == REQ_TICK;
  assign is_reg  = start && in_item.req_type == REQ_REGISTER;
  assign is_del  = start && in_item.req_type == REQ_DELETE;
  assign is_clr  = start && in_item.req_type == REQ_CLEAR;

  assign full   = search[SLOTS];
  assign del_ok = is_del && (total_r != '0) && sel_taken;

  assign cmd.tick   = is_tick;
  assign cmd.reg_go = is_reg & in_item.has_handler;
  assign cmd.del_go = del_ok;
  assign cmd.period = in_item.period;

  assign search[0] = 1'b1;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i < 8) begin : g_addr
      localparam logic [2:0] IDX3 = 3'(i);
      assign del_hit[i] = (in_item.slot_id == IDX3);
    end else begin : g_noaddr
      assign del_hit[i] = 1'b0;
    end

    ptst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .del_hit    (del_hit[i]),
      .search_in  (search[i]),
      .search_out (search[i+1]),
      .stat       (stat[i])
    );
  end

  // Gather the row status
  always_comb begin
    sel_taken = 1'b0;
    assigned  = 3'd0;
    fired     = 8'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (del_hit[i] && stat[i].taken) begin
        sel_taken = 1'b1;
      end
      if (stat[i].claimed) begin
        assigned = 3'(i);
      end
      if (i < 8 && stat[i].fired) begin
        fired[i] = 1'b1;
      end
    end
  end

  // Tick count and taken count
  assign tick_inc = ticks_r + 16'd1;

  always_comb begin
    ticks_nxt = ticks_r;
    total_nxt = total_r;
    if (is_tick) begin
      ticks_nxt = (tick_inc == wrap_r) ? 16'd0 : tick_inc;
    end
    if (is_clr) begin
      ticks_nxt = 16'd0;
    end
    if (cmd.reg_go && !full) begin
      total_nxt = total_r + CNT_W'(1);
    end
    if (del_ok) begin
      total_nxt = total_r - CNT_W'(1);
    end
  end

  // Build the result
  always_comb begin
    out_nxt               = '0;
    out_nxt.status        = ST_OK;
    out_nxt.fired_mask    = fired;
    out_nxt.system_ticks  = ticks_nxt;
    out_nxt.active_slots  = total_nxt[3:0];
    if (is_reg) begin
      if (!in_item.has_handler) begin
        out_nxt.status = ST_NULL;
      end else if (full) begin
        out_nxt.status = ST_FULL;
      end else begin
        out_nxt.assigned_slot = assigned;
      end
    end
    if (is_del) begin
      if (total_r == '0) begin
        out_nxt.status = ST_EMPTY;
      end else if (!sel_taken) begin
        out_nxt.status = ST_NOT_TAKEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r  <= 16'd0;
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      ticks_r  <= ticks_nxt;
      total_r  <= total_nxt;
      strobe_r <= start;
    end
  end

  // Hold the result for its transfer cycle
  always_ff @(posedge clk) begin
    if (start) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule
